### rtl/hgp_pkg.sv
package hgp_pkg;

	// Phase resolution kept from the fractional product, in bits.
	localparam int PHASE_BITS = 16;

	// Field and state widths.
	localparam int FREQ_W    = 23;
	localparam int PAT_W     = 2;
	localparam int LEG_MSK_W = 6;
	localparam int DT_W      = 16;
	localparam int ELAPSED_W = 48;
	localparam int PHASE_W   = 32;
	localparam int OUT_W     = 16;
	localparam int NUM_LEGS  = 6;
	localparam int LEG_IDX_W = 3;
	localparam int CFG_IDX_W = 2;

	// Shared multiplier operand widths.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 23;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Register reset values and the frequency floor.
	localparam logic [FREQ_W-1:0]    FREQ_RESET = 23'd65536;
	localparam logic [FREQ_W-1:0]    FREQ_MIN   = 23'd655;
	localparam logic [LEG_MSK_W-1:0] MASK_RESET = 6'd21;

	// Reciprocal of five: floor(w / 5) == (w * RECIP5) >> RECIP_SHIFT for w below 2^19.
	localparam logic [MUL_B_W-1:0] RECIP5      = 23'd838861;
	localparam int                 RECIP_SHIFT = 22;

	// Clears the phase bits below the kept resolution.
	localparam logic [PHASE_W-1:0] PHASE_KEEP =
		~((32'd1 << (PHASE_W - PHASE_BITS)) - 32'd1);

	// Gait pattern codes; the unused code runs as tripod.
	localparam logic [PAT_W-1:0] PAT_TRIPOD = 2'd0;
	localparam logic [PAT_W-1:0] PAT_WAVE   = 2'd1;
	localparam logic [PAT_W-1:0] PAT_RIPPLE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FREQ    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd2;

	// Ripple gait group of each leg: {0,5}, {1,4}, {2,3}.
	function automatic logic [LEG_IDX_W-1:0] ripple_group(input logic [LEG_IDX_W-1:0] leg);
		logic [LEG_IDX_W-1:0] g;
		unique case (leg)
			3'd0, 3'd5: g = 3'd0;
			3'd1, 3'd4: g = 3'd1;
			3'd2, 3'd3: g = 3'd2;
			default:    g = 3'd0;
		endcase
		return g;
	endfunction

endpackage

### rtl/hexapod_gait_phase_generator_unit.sv
// An accepted tick runs through the phase, scale, leg and store steps to the output
// register, one tick at a time. One shared 32x23 multiplier forms the phase, scales
// it by the leg count and, for the wave pattern, divides by five for each of the six
// legs in turn. A held result lets the next tick in; that tick then waits at its
// last step. Reset (arst_n low, asynchronous) clears elapsed time and the output
// valid and loads frequency 1.0 Hz, tripod pattern and tripod group A mask 21.
module hexapod_gait_phase_generator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hgp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hgp_pkg::FREQ_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [hgp_pkg::DT_W-1:0]             tick_dt,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [hgp_pkg::OUT_W-1:0]            cycle_phase,
	output logic [hgp_pkg::LEG_MSK_W-1:0]        swing_mask,
	output logic [hgp_pkg::OUT_W-1:0]            leg0_fraction,
	output logic [hgp_pkg::OUT_W-1:0]            leg1_fraction,
	output logic [hgp_pkg::OUT_W-1:0]            leg2_fraction,
	output logic [hgp_pkg::OUT_W-1:0]            leg3_fraction,
	output logic [hgp_pkg::OUT_W-1:0]            leg4_fraction,
	output logic [hgp_pkg::OUT_W-1:0]            leg5_fraction
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PHASE,
		ST_SCALE,
		ST_LEG,
		ST_STORE
	} state_t;

	state_t state_q;

	// Configuration and accumulator.
	logic [hgp_pkg::FREQ_W-1:0]    freq_q;
	logic [hgp_pkg::PAT_W-1:0]     pattern_q;
	logic [hgp_pkg::LEG_MSK_W-1:0] mask_q;
	logic [hgp_pkg::ELAPSED_W-1:0] elapsed_q;

	// Working registers.
	logic [hgp_pkg::PHASE_W-1:0]   p_q;
	logic [hgp_pkg::LEG_IDX_W-1:0] k_q;
	logic [hgp_pkg::PHASE_W-1:0]   fr_q;
	logic [hgp_pkg::LEG_IDX_W-1:0] leg_q;
	logic [hgp_pkg::OUT_W-1:0]     frac_q [hgp_pkg::NUM_LEGS];
	logic [hgp_pkg::LEG_MSK_W-1:0] swing_q;

	// Output register.
	logic                          out_valid_q;
	logic [hgp_pkg::OUT_W-1:0]     phase_out_q;
	logic [hgp_pkg::LEG_MSK_W-1:0] swing_out_q;
	logic [hgp_pkg::OUT_W-1:0]     frac_out_q [hgp_pkg::NUM_LEGS];

	// Shared multiplier.
	logic [hgp_pkg::MUL_A_W-1:0] mul_a;
	logic [hgp_pkg::MUL_B_W-1:0] mul_b;
	logic [hgp_pkg::MUL_P_W-1:0] prod;

	// Leg helpers.
	logic                          is_wave;
	logic                          is_cyclic;
	logic [hgp_pkg::LEG_IDX_W-1:0] leg_count;
	logic [hgp_pkg::LEG_IDX_W-1:0] leg_off;
	logic [hgp_pkg::FREQ_W-1:0]    freq_eff;
	logic [3:0]                    rel_sum;
	logic [hgp_pkg::LEG_IDX_W-1:0] rel_phase;
	logic [hgp_pkg::LEG_IDX_W-1:0] rel_m1;
	logic [18:0]                   div_num;
	logic [hgp_pkg::OUT_W-1:0]     leg_frac;
	logic                          leg_swing;
	logic                          out_free;

	assign is_wave   = (pattern_q == hgp_pkg::PAT_WAVE);
	assign is_cyclic = is_wave || (pattern_q == hgp_pkg::PAT_RIPPLE);
	assign leg_count = is_wave ? 3'd6 : 3'd3;
	assign leg_off   = is_wave ? leg_q : hgp_pkg::ripple_group(leg_q);
	assign freq_eff  = (freq_q < hgp_pkg::FREQ_MIN) ? hgp_pkg::FREQ_MIN : freq_q;

	// Position of this leg's cycle relative to the integer part of n*p, modulo n.
	assign rel_sum   = {1'b0, k_q} + {1'b0, leg_count} - {1'b0, leg_off};
	assign rel_phase = (rel_sum >= {1'b0, leg_count}) ?
		3'(rel_sum - {1'b0, leg_count}) : rel_sum[2:0];
	assign rel_m1    = rel_phase - 3'd1;
	assign div_num   = {rel_m1, fr_q[31:16]};

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_PHASE: begin
				mul_a = elapsed_q[hgp_pkg::MUL_A_W-1:0];
				mul_b = freq_eff;
			end
			ST_SCALE: begin
				mul_a = p_q;
				mul_b = {20'd0, leg_count};
			end
			ST_LEG: begin
				mul_a = {13'd0, div_num};
				mul_b = hgp_pkg::RECIP5;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {{hgp_pkg::MUL_B_W{1'b0}}, mul_a} * {{hgp_pkg::MUL_A_W{1'b0}}, mul_b};

	// Fraction and swing flag of the current leg.
	always_comb begin
		if (!is_cyclic) begin
			leg_frac  = p_q[30:15];
			leg_swing = p_q[31] ? mask_q[leg_q] : ~mask_q[leg_q];
		end else if (rel_phase == 3'd0) begin
			leg_frac  = fr_q[31:16];
			leg_swing = 1'b1;
		end else if (is_wave) begin
			leg_frac  = prod[hgp_pkg::RECIP_SHIFT +: hgp_pkg::OUT_W];
			leg_swing = 1'b0;
		end else begin
			leg_frac  = {rel_m1[0], fr_q[31:17]};
			leg_swing = 1'b0;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Sequencer, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			freq_q      <= hgp_pkg::FREQ_RESET;
			pattern_q   <= hgp_pkg::PAT_TRIPOD;
			mask_q      <= hgp_pkg::MASK_RESET;
			elapsed_q   <= '0;
			leg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hgp_pkg::REG_FREQ:    freq_q    <= cfg_data;
					hgp_pkg::REG_PATTERN: pattern_q <= cfg_data[hgp_pkg::PAT_W-1:0];
					hgp_pkg::REG_MASK:    mask_q    <= cfg_data[hgp_pkg::LEG_MSK_W-1:0];
					default: ;
				endcase
			end

			// The store step reloads the valid itself when it hands over a result.
			if (out_valid_q && out_ready && state_q != ST_STORE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						elapsed_q <= elapsed_q + {32'd0, tick_dt};
						state_q   <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					p_q     <= prod[hgp_pkg::PHASE_W-1:0] & hgp_pkg::PHASE_KEEP;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					k_q     <= prod[34:32];
					fr_q    <= prod[hgp_pkg::PHASE_W-1:0];
					leg_q   <= '0;
					state_q <= ST_LEG;
				end
				ST_LEG: begin
					frac_q[leg_q]  <= leg_frac;
					swing_q[leg_q] <= leg_swing;
					if (leg_q == 3'(hgp_pkg::NUM_LEGS - 1)) begin
						state_q <= ST_STORE;
					end else begin
						leg_q <= leg_q + 3'd1;
					end
				end
				ST_STORE: begin
					// Hand the result over once the output register is free.
					if (out_free) begin
						out_valid_q <= 1'b1;
						phase_out_q <= p_q[31:16];
						swing_out_q <= swing_q;
						frac_out_q  <= frac_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign cycle_phase   = phase_out_q;
	assign swing_mask    = swing_out_q;
	assign leg0_fraction = frac_out_q[0];
	assign leg1_fraction = frac_out_q[1];
	assign leg2_fraction = frac_out_q[2];
	assign leg3_fraction = frac_out_q[3];
	assign leg4_fraction = frac_out_q[4];
	assign leg5_fraction = frac_out_q[5];

endmodule

### rtl/hgp_checker.sv
module hgp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hgp_pkg::OUT_W-1:0]     cycle_phase,
	input logic [hgp_pkg::LEG_MSK_W-1:0] swing_mask
);

	// A stalled result transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cycle_phase) && $stable(swing_mask))
		else $error("stalled result changed");

	// The unit is busy right after it takes a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("tick accepted while busy");

	// The sequencer stays busy through the leg passes.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##8 !in_ready)
		else $error("tick processing ended early");

	// A new result appears only as the sequencer finishes.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a busy period");

endmodule

bind hexapod_gait_phase_generator_unit hgp_checker u_hgp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.cycle_phase (cycle_phase),
	.swing_mask  (swing_mask)
);
